### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("implication check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("next-cycle check failed");

`endif

### rtl/ebc_pkg.sv
`default_nettype none
package ebc_pkg;

   // fixed field and state widths
   localparam int NUM_CH    = 3;
   localparam int CH_W      = 2;
   localparam int SUM_W     = 30;
   localparam int SQ_W      = 40;
   localparam int MEAN_W    = 17;
   localparam int DEV_W     = 16;
   localparam int FRAC_BITS = 4;
   localparam int CFG_W     = 16;
   localparam int RATE_W    = 10;
   localparam int PROD_W    = RATE_W + CFG_W;
   localparam int MS_W      = 10;
   localparam int SAT_MARGIN = 4;

   // configuration defaults and limits
   localparam logic [CFG_W-1:0] RATE_DEFAULT     = 16'd200;
   localparam logic [CFG_W-1:0] RATE_MAX         = 16'd1000;
   localparam logic [CFG_W-1:0] DURATION_DEFAULT = 16'd3000;
   localparam logic [MS_W-1:0]  MS_PER_S         = 10'd1000;

   // register indexes
   localparam int CSR_INDEX_W = 1;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAMPLE_RATE       = 1'b0,
      CSR_BASELINE_DURATION = 1'b1
   } csr_index_type;

   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic        [SQ_W-1:0]   square_sum_type;
   typedef logic signed [MEAN_W-1:0] mean_type;
   typedef logic        [DEV_W-1:0]  deviation_type;

   // result saturation limits
   localparam mean_type      MEAN_MAX = 17'sd65535;
   localparam mean_type      MEAN_MIN = -17'sd65536;
   localparam deviation_type DEV_MAX  = 16'hFFFF;

endpackage
`default_nettype wire

### rtl/ebc_req_if.sv
`default_nettype none
interface ebc_req_if #(parameter int ADC_BITS = 12);
   logic                valid;
   logic                ready;
   logic                start_request;
   logic [ADC_BITS-1:0] adc_ch0;
   logic [ADC_BITS-1:0] adc_ch1;
   logic [ADC_BITS-1:0] adc_ch2;

   modport source (output valid, start_request, adc_ch0, adc_ch1, adc_ch2, input ready);
   modport sink (input valid, start_request, adc_ch0, adc_ch1, adc_ch2, output ready);
endinterface
`default_nettype wire

### rtl/ebc_rsp_if.sv
`default_nettype none
interface ebc_rsp_if #(parameter int ADC_BITS = 12);
   import ebc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [ADC_BITS:0] centered_ch0;
   logic signed [ADC_BITS:0] centered_ch1;
   logic signed [ADC_BITS:0] centered_ch2;
   logic [NUM_CH-1:0]        saturation_mask;
   logic                     baseline_valid;
   logic                     baseline_done;
   mean_type                 mean_ch0;
   mean_type                 mean_ch1;
   mean_type                 mean_ch2;
   deviation_type            deviation_ch0;
   deviation_type            deviation_ch1;
   deviation_type            deviation_ch2;

   modport source (output valid, centered_ch0, centered_ch1, centered_ch2, saturation_mask,
      baseline_valid, baseline_done, mean_ch0, mean_ch1, mean_ch2, deviation_ch0,
      deviation_ch1, deviation_ch2, input ready);
   modport sink (input valid, centered_ch0, centered_ch1, centered_ch2, saturation_mask,
      baseline_valid, baseline_done, mean_ch0, mean_ch1, mean_ch2, deviation_ch0,
      deviation_ch1, deviation_ch2, output ready);
endinterface
`default_nettype wire

### rtl/emg_baseline_calibrator.sv
// a word outside a baseline window is centred and registered as the result;
// a word inside a window is also squared bit-serially per channel and accumulated;
// a start request first runs a serial divide by 1000 that sets the window length;
// the word closing a window also runs the shared serial finish unit per channel.
// one word in flight: the next is taken as soon as the result is registered.
// reset (synchronous, active high): 200 Hz, 3000 ms, sums and held results zero, valid low.
`default_nettype none
`include "assert_macros.svh"
module emg_baseline_calibrator #(
   parameter int ADC_BITS   = 12,
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   ebc_req_if.sink                         req_port,
   ebc_rsp_if.source                       rsp_port,
   input  logic                            csr_write_enable,
   input  logic [ebc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ebc_pkg::CFG_W-1:0]       csr_write_data
);
   import ebc_pkg::*;

   localparam int CEN_W  = ADC_BITS + 1;
   localparam int SQR_W  = 2 * ADC_BITS;
   localparam int STEP_W = $clog2(PROD_W + 1);
   localparam logic [ADC_BITS-1:0]   ADC_MAX   = '1;
   localparam logic [ADC_BITS-1:0]   ADC_MID   = ADC_MAX >> 1;
   localparam logic [ADC_BITS-1:0]   SAT_LO    = ADC_BITS'(SAT_MARGIN);
   localparam logic [ADC_BITS-1:0]   SAT_HI    = ADC_MAX - SAT_LO;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      S_IDLE, S_COUNT, S_LOAD, S_SQUARE, S_ACC, S_FIN_GO, S_FIN_WAIT, S_DONE
   } state_type;

   state_type               state_ff;
   logic [CH_W-1:0]         ch_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [CFG_W-1:0]        rate_ff;
   logic [CFG_W-1:0]        dur_ff;
   logic [ADC_BITS-1:0]     raw_ff [NUM_CH];
   sum_type                 sum_ff [NUM_CH];
   square_sum_type          sq_ff [NUM_CH];
   mean_type                mean_ff [NUM_CH];
   deviation_type           dev_ff [NUM_CH];
   logic [COUNT_BITS-1:0]   left_ff;
   logic [COUNT_BITS-1:0]   len_ff;
   logic                    active_ff;
   logic                    valid_ff;
   logic                    item_done_ff;
   logic [PROD_W-1:0]       cnt_quo_ff;
   logic [MS_W-1:0]         cnt_rem_ff;
   logic [SQR_W-1:0]        sq_mcd_ff;
   logic [ADC_BITS-1:0]     sq_mpl_ff;
   logic [SQR_W-1:0]        sq_prod_ff;

   // registered result word
   logic                    rsp_valid_ff;
   logic signed [CEN_W-1:0] out_cen_ff [NUM_CH];
   logic [NUM_CH-1:0]       out_mask_ff;
   logic                    out_valid_ff;
   logic                    out_done_ff;
   mean_type                out_mean_ff [NUM_CH];
   deviation_type           out_dev_ff [NUM_CH];

   logic signed [CEN_W-1:0] cen [NUM_CH];
   logic [NUM_CH-1:0]       mask;
   logic signed [CEN_W-1:0] cen_sel;
   logic [CEN_W-1:0]        cen_neg;
   logic [ADC_BITS-1:0]     mag;
   logic [RATE_W-1:0]       rate_clean;
   logic [PROD_W-1:0]       product_in;
   logic [MS_W:0]           cnt_trial;
   logic                    cnt_ge;
   logic [MS_W-1:0]         cnt_rem_in;
   logic [PROD_W-1:0]       cnt_quo_in;
   logic [COUNT_BITS-1:0]   target_in;
   logic                    accept;
   logic                    fin_start;
   logic                    fin_done;
   mean_type                fin_mean;
   deviation_type           fin_dev;

   // centring and rail flags
   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         cen[i]  = $signed({1'b0, raw_ff[i]}) - $signed({1'b0, ADC_MID});
         mask[i] = (raw_ff[i] <= SAT_LO) || (raw_ff[i] >= SAT_HI);
      end
   end

   // magnitude of the channel being squared
   assign cen_sel = cen[ch_ff];
   assign cen_neg = -cen_sel;
   assign mag     = cen_sel[CEN_W-1] ? cen_neg[ADC_BITS-1:0] : cen_sel[ADC_BITS-1:0];

   // cleaned rate times duration
   always_comb begin
      if (rate_ff == '0) rate_clean = RATE_W'(RATE_DEFAULT);
      else if (rate_ff > RATE_MAX) rate_clean = RATE_W'(RATE_MAX);
      else rate_clean = rate_ff[RATE_W-1:0];
      product_in = PROD_W'(rate_clean) * PROD_W'(dur_ff);
   end

   // divide by 1000 one bit a cycle, then clamp the window length
   always_comb begin
      cnt_trial  = {cnt_rem_ff, cnt_quo_ff[PROD_W-1]};
      cnt_ge     = cnt_trial >= {1'b0, MS_PER_S};
      cnt_rem_in = cnt_ge ? MS_W'(cnt_trial - {1'b0, MS_PER_S}) : cnt_trial[MS_W-1:0];
      cnt_quo_in = {cnt_quo_ff[PROD_W-2:0], cnt_ge};
      if (cnt_quo_in == '0) target_in = COUNT_BITS'(1);
      else if (cnt_quo_in > PROD_W'(COUNT_MAX)) target_in = COUNT_MAX;
      else target_in = cnt_quo_in[COUNT_BITS-1:0];
   end

   assign accept    = req_port.valid && req_port.ready;
   assign fin_start = (state_ff == S_FIN_GO);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_DEFAULT;
         dur_ff  <= DURATION_DEFAULT;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SAMPLE_RATE:       rate_ff <= csr_write_data;
            CSR_BASELINE_DURATION: dur_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // sequencer, window state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= '0;
         step_ff      <= '0;
         left_ff      <= '0;
         len_ff       <= '0;
         active_ff    <= 1'b0;
         valid_ff     <= 1'b0;
         item_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            sum_ff[i]  <= '0;
            sq_ff[i]   <= '0;
            mean_ff[i] <= '0;
            dev_ff[i]  <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_port.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  raw_ff[0]    <= req_port.adc_ch0;
                  raw_ff[1]    <= req_port.adc_ch1;
                  raw_ff[2]    <= req_port.adc_ch2;
                  item_done_ff <= 1'b0;
                  ch_ff        <= '0;
                  if (req_port.start_request) begin
                     for (int i = 0; i < NUM_CH; i++) begin
                        sum_ff[i] <= '0;
                        sq_ff[i]  <= '0;
                     end
                     valid_ff   <= 1'b0;
                     active_ff  <= 1'b1;
                     cnt_quo_ff <= product_in;
                     cnt_rem_ff <= '0;
                     step_ff    <= '0;
                     state_ff   <= S_COUNT;
                  end else if (active_ff && left_ff != '0) begin
                     state_ff <= S_LOAD;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_COUNT: begin
               cnt_quo_ff <= cnt_quo_in;
               cnt_rem_ff <= cnt_rem_in;
               step_ff    <= step_ff + 1'b1;
               if (step_ff == STEP_W'(PROD_W - 1)) begin
                  len_ff   <= target_in;
                  left_ff  <= target_in;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               sq_mcd_ff  <= SQR_W'(mag);
               sq_mpl_ff  <= mag;
               sq_prod_ff <= '0;
               step_ff    <= '0;
               state_ff   <= S_SQUARE;
            end
            // shift-add square of the centred sample
            S_SQUARE: begin
               if (sq_mpl_ff[0]) sq_prod_ff <= sq_prod_ff + sq_mcd_ff;
               sq_mcd_ff <= {sq_mcd_ff[SQR_W-2:0], 1'b0};
               sq_mpl_ff <= {1'b0, sq_mpl_ff[ADC_BITS-1:1]};
               step_ff   <= step_ff + 1'b1;
               if (step_ff == STEP_W'(ADC_BITS - 1)) state_ff <= S_ACC;
            end
            S_ACC: begin
               sum_ff[ch_ff] <= sum_ff[ch_ff] + SUM_W'(cen_sel);
               sq_ff[ch_ff]  <= sq_ff[ch_ff] + SQ_W'(sq_prod_ff);
               if (ch_ff == CH_W'(NUM_CH - 1)) begin
                  left_ff <= left_ff - 1'b1;
                  ch_ff   <= '0;
                  if (left_ff == COUNT_BITS'(1)) begin
                     active_ff <= 1'b0;
                     state_ff  <= S_FIN_GO;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  ch_ff    <= ch_ff + 1'b1;
                  state_ff <= S_LOAD;
               end
            end
            S_FIN_GO: state_ff <= S_FIN_WAIT;
            S_FIN_WAIT: begin
               if (fin_done) begin
                  mean_ff[ch_ff] <= fin_mean;
                  dev_ff[ch_ff]  <= fin_dev;
                  if (ch_ff == CH_W'(NUM_CH - 1)) begin
                     valid_ff     <= 1'b1;
                     item_done_ff <= 1'b1;
                     state_ff     <= S_DONE;
                  end else begin
                     ch_ff    <= ch_ff + 1'b1;
                     state_ff <= S_FIN_GO;
                  end
               end
            end
            // hand the word to the output register once it is free
            S_DONE: begin
               if (!rsp_valid_ff || rsp_port.ready) begin
                  rsp_valid_ff <= 1'b1;
                  out_mask_ff  <= mask;
                  out_valid_ff <= valid_ff;
                  out_done_ff  <= item_done_ff;
                  for (int i = 0; i < NUM_CH; i++) begin
                     out_cen_ff[i]  <= cen[i];
                     out_mean_ff[i] <= mean_ff[i];
                     out_dev_ff[i]  <= dev_ff[i];
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   ebc_finish #(
      .COUNT_BITS (COUNT_BITS)
   ) u_finish (
      .clock      (clock),
      .reset      (reset),
      .start      (fin_start),
      .sum        (sum_ff[ch_ff]),
      .square_sum (sq_ff[ch_ff]),
      .length     (len_ff),
      .mean       (fin_mean),
      .deviation  (fin_dev),
      .done       (fin_done)
   );

   // port drive
   assign req_port.ready           = (state_ff == S_IDLE);
   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.centered_ch0    = out_cen_ff[0];
   assign rsp_port.centered_ch1    = out_cen_ff[1];
   assign rsp_port.centered_ch2    = out_cen_ff[2];
   assign rsp_port.saturation_mask = out_mask_ff;
   assign rsp_port.baseline_valid  = out_valid_ff;
   assign rsp_port.baseline_done   = out_done_ff;
   assign rsp_port.mean_ch0        = out_mean_ff[0];
   assign rsp_port.mean_ch1        = out_mean_ff[1];
   assign rsp_port.mean_ch2        = out_mean_ff[2];
   assign rsp_port.deviation_ch0   = out_dev_ff[0];
   assign rsp_port.deviation_ch1   = out_dev_ff[1];
   assign rsp_port.deviation_ch2   = out_dev_ff[2];

   `ASSERT_IMPLIES(a_window_count, clock, reset, active_ff && state_ff == S_IDLE, left_ff != '0 && left_ff <= len_ff)
   `ASSERT_IMPLIES(a_valid_closed, clock, reset, valid_ff, !active_ff)
   `ASSERT_IMPLIES(a_done_has_valid, clock, reset, rsp_valid_ff && out_done_ff, out_valid_ff)

endmodule
`default_nettype wire

### rtl/ebc_finish.sv
`default_nettype none
`include "assert_macros.svh"
module ebc_finish #(
   parameter int COUNT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  ebc_pkg::sum_type        sum,
   input  ebc_pkg::square_sum_type square_sum,
   input  logic [COUNT_BITS-1:0]   length,
   output ebc_pkg::mean_type       mean,
   output ebc_pkg::deviation_type  deviation,
   output logic                    done
);
   import ebc_pkg::*;

   localparam int MAG_W  = SUM_W;
   localparam int MDIV_W = MAG_W + FRAC_BITS;
   localparam int NQ_W   = COUNT_BITS + SQ_W;
   localparam int SS_W   = 2 * MAG_W;
   localparam int MCD_W  = (NQ_W > SS_W) ? NQ_W : SS_W;
   localparam int DW     = MCD_W + 1;
   localparam int RAD_W0 = MCD_W + 2 * FRAC_BITS;
   localparam int RW     = (RAD_W0 + 1) / 2;
   localparam int RAD_W  = 2 * RW;
   localparam int RREM_W = RW + 1;
   localparam int QW     = (MDIV_W > RW) ? MDIV_W : RW;
   localparam int MPL_W  = (COUNT_BITS > MAG_W) ? COUNT_BITS : MAG_W;
   localparam int MAX_IT = (QW > MPL_W) ? QW : MPL_W;
   localparam int IT_W   = $clog2(MAX_IT + 1);

   typedef enum logic [2:0] {
      F_IDLE, F_MUL_NQ, F_MUL_SS, F_MEAN, F_MEAN_END, F_ROOT, F_DEV, F_DONE
   } state_type;

   state_type               state_ff;
   logic [IT_W-1:0]         it_ff;
   logic                    neg_ff;
   logic [MAG_W-1:0]        mag_ff;
   logic [COUNT_BITS-1:0]   len_ff;
   logic [MCD_W-1:0]        mcd_ff;
   logic [MPL_W-1:0]        mpl_ff;
   logic signed [DW-1:0]    acc_ff;
   logic [QW-1:0]           quo_ff;
   logic [COUNT_BITS-1:0]   drem_ff;
   logic [RAD_W-1:0]        rad_ff;
   logic [RW-1:0]           root_ff;
   logic [RREM_W-1:0]       rrem_ff;
   mean_type                mean_ff;
   deviation_type           dev_ff;
   logic                    done_ff;

   logic [MAG_W-1:0]        sum_neg;
   logic [MAG_W-1:0]        mag_in;
   logic [COUNT_BITS:0]     dtrial;
   logic                    dge;
   logic [COUNT_BITS-1:0]   drem_in;
   logic [QW-1:0]           quo_in;
   logic [RREM_W+1:0]       rshift;
   logic [RREM_W+1:0]       rtrial;
   logic                    rge;
   logic [RREM_W-1:0]       rrem_in;
   logic [RW-1:0]           root_in;
   logic [QW:0]             mean_mag;
   logic [QW:0]             mean_neg;
   logic [MCD_W-1:0]        dpos;

   // magnitude of the signed sum
   assign sum_neg = -sum;
   assign mag_in  = sum[SUM_W-1] ? sum_neg : sum;

   // restoring divide by the window length, one quotient bit a cycle
   always_comb begin
      dtrial  = {drem_ff, quo_ff[QW-1]};
      dge     = dtrial >= {1'b0, len_ff};
      drem_in = dge ? COUNT_BITS'(dtrial - {1'b0, len_ff}) : dtrial[COUNT_BITS-1:0];
      quo_in  = {quo_ff[QW-2:0], dge};
   end

   // square root, two radicand bits and one root bit a cycle
   always_comb begin
      rshift  = {rrem_ff, rad_ff[RAD_W-1:RAD_W-2]};
      rtrial  = (RREM_W + 2)'({root_ff, 2'b01});
      rge     = rshift >= rtrial;
      rrem_in = rge ? RREM_W'(rshift - rtrial) : RREM_W'(rshift);
      root_in = {root_ff[RW-2:0], rge};
   end

   // floored mean from quotient and remainder, and the clamped variance term
   always_comb begin
      mean_mag = (QW + 1)'(quo_ff) + (QW + 1)'(|drem_ff);
      mean_neg = -mean_mag;
      dpos     = acc_ff[DW-1] ? '0 : acc_ff[MCD_W-1:0];
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= F_IDLE;
         it_ff    <= '0;
         mean_ff  <= '0;
         dev_ff   <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (start) begin
                  neg_ff   <= sum[SUM_W-1];
                  mag_ff   <= mag_in;
                  len_ff   <= length;
                  mcd_ff   <= MCD_W'(square_sum);
                  mpl_ff   <= MPL_W'(length);
                  acc_ff   <= '0;
                  it_ff    <= '0;
                  state_ff <= F_MUL_NQ;
               end
            end
            // length times sum of squares
            F_MUL_NQ: begin
               if (mpl_ff[0]) acc_ff <= acc_ff + $signed({1'b0, mcd_ff});
               mcd_ff <= {mcd_ff[MCD_W-2:0], 1'b0};
               mpl_ff <= {1'b0, mpl_ff[MPL_W-1:1]};
               it_ff  <= it_ff + 1'b1;
               if (it_ff == IT_W'(COUNT_BITS - 1)) begin
                  mcd_ff   <= MCD_W'(mag_ff);
                  mpl_ff   <= MPL_W'(mag_ff);
                  it_ff    <= '0;
                  state_ff <= F_MUL_SS;
               end
            end
            // minus the square of the sum
            F_MUL_SS: begin
               if (mpl_ff[0]) acc_ff <= acc_ff - $signed({1'b0, mcd_ff});
               mcd_ff <= {mcd_ff[MCD_W-2:0], 1'b0};
               mpl_ff <= {1'b0, mpl_ff[MPL_W-1:1]};
               it_ff  <= it_ff + 1'b1;
               if (it_ff == IT_W'(MAG_W - 1)) begin
                  quo_ff   <= QW'({mag_ff, FRAC_BITS'(0)});
                  drem_ff  <= '0;
                  it_ff    <= '0;
                  state_ff <= F_MEAN;
               end
            end
            F_MEAN: begin
               quo_ff  <= quo_in;
               drem_ff <= drem_in;
               it_ff   <= it_ff + 1'b1;
               if (it_ff == IT_W'(QW - 1)) state_ff <= F_MEAN_END;
            end
            // floor and saturate the mean, then load the radicand
            F_MEAN_END: begin
               if (!neg_ff) begin
                  mean_ff <= (quo_ff > QW'(MEAN_MAX)) ? MEAN_MAX : MEAN_W'(quo_ff);
               end else begin
                  mean_ff <= (mean_mag > (QW + 1)'(17'd65536)) ? MEAN_MIN : MEAN_W'(mean_neg);
               end
               rad_ff   <= RAD_W'({dpos, (2 * FRAC_BITS)'(0)});
               root_ff  <= '0;
               rrem_ff  <= '0;
               it_ff    <= '0;
               state_ff <= F_ROOT;
            end
            F_ROOT: begin
               rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
               root_ff <= root_in;
               rrem_ff <= rrem_in;
               it_ff   <= it_ff + 1'b1;
               if (it_ff == IT_W'(RW - 1)) begin
                  quo_ff   <= QW'(root_in);
                  drem_ff  <= '0;
                  it_ff    <= '0;
                  state_ff <= F_DEV;
               end
            end
            F_DEV: begin
               quo_ff  <= quo_in;
               drem_ff <= drem_in;
               it_ff   <= it_ff + 1'b1;
               if (it_ff == IT_W'(QW - 1)) state_ff <= F_DONE;
            end
            F_DONE: begin
               dev_ff   <= (quo_ff > QW'(DEV_MAX)) ? DEV_MAX : DEV_W'(quo_ff);
               done_ff  <= 1'b1;
               state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign mean      = mean_ff;
   assign deviation = dev_ff;
   assign done      = done_ff;

   `ASSERT_IMPLIES(a_div_rem_bound, clock, reset, state_ff == F_MEAN || state_ff == F_DEV, drem_ff < len_ff)
   `ASSERT_IMPLIES(a_root_rem_bound, clock, reset, state_ff == F_ROOT, rrem_ff <= {root_ff, 1'b0})
   `ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff)

endmodule
`default_nettype wire
